>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the mip downsampler.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

>>> rtl/core/eqmip_pkg.sv
// Types, codes and the sine table function of the mip downsampler.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package eqmip_pkg;

   localparam int MAX_LOG2 = 12;
   localparam int NUM_LANES = 4;
   localparam int WEIGHT_W = 16;
   localparam int SUM_W = 9;
   localparam int NUM_W = 26;
   localparam int DEN_W = 18;

   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_WLOG = 2'd1;
   localparam logic [1:0] REG_HLOG = 2'd2;

   localparam logic [1:0] MODE_POINT = 2'd0;
   localparam logic [1:0] MODE_BOX = 2'd1;
   localparam logic [1:0] MODE_EQUI = 2'd2;

   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } pix_in_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
      logic       level_done;
   } mip_out_type;

   typedef enum logic [2:0] {
      S_IDLE, S_W0, S_W1, S_CH, S_MUL, S_DIV, S_WAIT, S_PUSH
   } state_type;

   // Q1.15 value of sin(pi*k/2^bits), evaluated as a Taylor series in Q30.
   function automatic logic [15:0] sine_value(input int unsigned k, input int unsigned bits);
      logic [63:0] full;
      logic [63:0] kk;
      logic [63:0] km;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      full = 64'd1 << bits;
      km = 64'(k) & (full - 64'd1);
      kk = (km > (full >> 1)) ? full - km : km;
      x = (PI_Q30 * kk) >> bits;
      x2 = (x * x) >> 30;
      t = Q30_ONE - x2 / 110;
      t = Q30_ONE - ((x2 * t) >> 30) / 72;
      t = Q30_ONE - ((x2 * t) >> 30) / 42;
      t = Q30_ONE - ((x2 * t) >> 30) / 20;
      t = Q30_ONE - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      s = (s + 64'd16384) >> 15;
      if (s > 64'd32768) s = 64'd32768;
      return s[15:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/eqmip_sine_rom.sv
// Registered-read sine weight table of the mip downsampler.
// Depends on eqmip_pkg for the table function.
`timescale 1ns / 1ps
`default_nettype none
module eqmip_sine_rom
   import eqmip_pkg::*;
#(
   parameter int ROM_BITS = 10
) (
   input  wire logic                  clock,
   input  wire logic [ROM_BITS-1:0]   addr,
   output logic      [WEIGHT_W-1:0]   data_ff
);

   localparam int ROM_DEPTH = 1 << ROM_BITS;

   logic [WEIGHT_W-1:0] rom_table [ROM_DEPTH];

   for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_entry
      assign rom_table[k] = sine_value(k, ROM_BITS);
   end

   always_ff @(posedge clock) begin
      data_ff <= rom_table[addr];
   end

endmodule
`default_nettype wire

>>> rtl/core/eqmip_divider.sv
// Restoring divider, one quotient bit per cycle, for the weighted mean.
// Depends on eqmip_pkg for the operand widths and on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module eqmip_divider
   import eqmip_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done_ff,
   output logic      [NUM_W-1:0] quo_ff
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W:0]   rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_sh;
   logic             fits;

   always_comb begin
      rem_sh = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      fits = rem_sh >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

   `ASSERT_PROP(a_start_idle, clock, reset, start |-> !busy_ff, "divider restarted while busy")
   `ASSERT_PROP(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff), "done without work")
   `ASSERT_PROP(a_cnt_range, clock, reset, busy_ff |-> (cnt_ff < CNT_W'(NUM_W)), "step count overrun")

endmodule
`default_nettype wire

>>> rtl/core/equirect_weighted_mip_downsample.sv
// Half-size mip generator. A pixel that closes a 2x2 block runs the sequencer: the two weight
// reads, one step per channel in point and box mode, or multiply, add and divide per channel in
// equirect mode, where the serial divider dominates; then the output register is loaded.
// Sustained rate: one pixel per cycle on even rows when idle; bursts between mip pixels on odd rows.
// Reset (synchronous) clears counters, the left pixel and the registers (mode 0, widths 10 and 9);
// the line buffer is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module equirect_weighted_mip_downsample
   import eqmip_pkg::*;
#(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int CHANNELS = 4,
   parameter int SINE_ROM_BITS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire pix_in_type  req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output mip_out_type      rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [3:0]  csr_data
);

   // Largest usable log2 sizes: the floor log2 of the maximum, capped at twelve.
   localparam int WFL = $clog2(MAX_WIDTH + 1) - 1;
   localparam int HFL = $clog2(MAX_HEIGHT + 1) - 1;
   localparam int WL_MAX = (WFL > MAX_LOG2) ? MAX_LOG2 : WFL;
   localparam int HL_MAX = (HFL > MAX_LOG2) ? MAX_LOG2 : HFL;
   localparam int CW = WL_MAX;
   localparam int RW = HL_MAX;
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int MEM_W = 8 * CHANNELS;
   localparam int RB = SINE_ROM_BITS;

   // Configuration registers.
   logic [1:0] mode_ff;
   logic [3:0] wlog_ff;
   logic [3:0] hlog_ff;

   // Position counters and the even-column pixel of the odd row.
   logic [CW-1:0]    col_ff;
   logic [RW-1:0]    row_ff;
   logic [MEM_W-1:0] left_ff;

   // Line buffer holding the even row of each row pair.
   logic [MEM_W-1:0] line_mem [MAX_WIDTH];
   logic [MEM_W-1:0] mem_q_ff;
   logic             mem_we;
   logic             mem_re;
   logic [AW-1:0]    mem_addr;

   // Block operands and the per-channel work.
   logic [MEM_W-1:0]    tl_ff;
   logic [MEM_W-1:0]    tr_ff;
   logic [MEM_W-1:0]    br_ff;
   logic                tl_load_ff;
   logic [RW-1:0]       r_ff;
   logic                last_ff;
   logic [WEIGHT_W-1:0] w0_ff;
   logic [WEIGHT_W-1:0] w1_ff;
   logic [1:0]          ch_ff;
   logic [NUM_W-1:0]    prod_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [7:0]          res_ff [NUM_LANES];

   state_type state_ff;
   state_type state_in;

   mip_out_type rsp_data_ff;
   logic        rsp_valid_ff;

   logic [3:0]    wl;
   logic [3:0]    hl;
   logic [CW-1:0] wmask;
   logic [RW-1:0] hmask;
   logic [CW-1:0] c;
   logic [RW-1:0] r;
   logic          last_col;
   logic          last_row;
   logic          accept;
   logic [31:0]   pix;

   logic [RW-1:0]       y_sel;
   logic [31:0]         y_shift;
   logic [RB-1:0]       rom_addr;
   logic [WEIGHT_W-1:0] rom_q;

   logic [31:0]      tl32;
   logic [31:0]      tr32;
   logic [31:0]      bl32;
   logic [31:0]      br32;
   logic [7:0]       tl_ch;
   logic [SUM_W-1:0] st;
   logic [SUM_W-1:0] sb;
   logic [SUM_W:0]   s4;
   logic [DEN_W-1:0] den;
   logic             lane_on;

   logic             div_start;
   logic             div_done;
   logic [NUM_W-1:0] div_quo;

   logic       res_load;
   logic [7:0] res_val;
   logic       rsp_load;

   // Effective sizes: clamp to one through twelve, then to what the buffers hold.
   always_comb begin
      wl = (wlog_ff == 4'd0) ? 4'd1 : ((wlog_ff > 4'd12) ? 4'd12 : wlog_ff);
      if (wl > 4'(WL_MAX)) wl = 4'(WL_MAX);
      hl = (hlog_ff == 4'd0) ? 4'd1 : ((hlog_ff > 4'd12) ? 4'd12 : hlog_ff);
      if (hl > 4'(HL_MAX)) hl = 4'(HL_MAX);
      wmask = ~({CW{1'b1}} << wl);
      hmask = ~({RW{1'b1}} << hl);
      c = col_ff & wmask;
      r = row_ff & hmask;
      last_col = (c == wmask);
      last_row = (r == hmask);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign pix = {req_data.alpha_in, req_data.blue_in, req_data.green_in, req_data.red_in};

   // Even rows write the buffer; odd rows read the upper neighbor. The two never meet.
   always_comb begin
      mem_we = accept && !r[0];
      mem_re = accept && r[0];
      mem_addr = AW'(c);
   end

   always_ff @(posedge clock) begin
      if (mem_we) line_mem[mem_addr] <= pix[MEM_W-1:0];
      if (mem_re) mem_q_ff <= line_mem[mem_addr];
   end

   // Row weight address: the row scaled to the table's index width.
   // While idle the block's upper (even) row is looked up, then its lower (odd) row.
   always_comb begin
      y_sel = (state_ff == S_IDLE) ? r - 1'b1 : r_ff;
      if (hl >= 4'(RB)) y_shift = 32'(y_sel) >> (hl - 4'(RB));
      else y_shift = 32'(y_sel) << (4'(RB) - hl);
      rom_addr = y_shift[RB-1:0];
   end

   eqmip_sine_rom #(
      .ROM_BITS(RB)
   ) u_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .data_ff (rom_q)
   );

   // Channel operands of the current lane.
   always_comb begin
      tl32 = 32'(tl_ff);
      tr32 = 32'(tr_ff);
      bl32 = 32'(left_ff);
      br32 = 32'(br_ff);
      tl_ch = tl32[8*ch_ff +: 8];
      st = SUM_W'(tl_ch) + SUM_W'(tr32[8*ch_ff +: 8]);
      sb = SUM_W'(bl32[8*ch_ff +: 8]) + SUM_W'(br32[8*ch_ff +: 8]);
      s4 = (SUM_W+1)'(st) + (SUM_W+1)'(sb);
      den = {(DEN_W-1)'(w0_ff) + (DEN_W-1)'(w1_ff), 1'b0};
      lane_on = int'(ch_ff) < CHANNELS;
   end

   eqmip_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (num_ff),
      .den     (den),
      .done_ff (div_done),
      .quo_ff  (div_quo)
   );

   // Sequencer: weights, then each channel in turn, then the output register.
   always_comb begin
      state_in = state_ff;
      div_start = 1'b0;
      res_load = 1'b0;
      res_val = 8'd0;
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && r[0] && c[0]) state_in = S_W0;
         end
         S_W0: state_in = S_W1;
         S_W1: state_in = S_CH;
         S_CH: begin
            if (lane_on && mode_ff == MODE_EQUI) begin
               state_in = S_MUL;
            end else begin
               res_load = 1'b1;
               if (!lane_on) res_val = 8'd0;
               else if (mode_ff == MODE_BOX) res_val = s4[SUM_W:2];
               else res_val = tl_ch;
            end
         end
         S_MUL: state_in = S_DIV;
         S_DIV: begin
            if (den == '0) begin
               res_load = 1'b1;
               res_val = 8'd0;
            end else begin
               div_start = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (div_done) begin
               res_load = 1'b1;
               res_val = div_quo[7:0];
            end
         end
         S_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (res_load) state_in = (ch_ff == 2'(NUM_LANES - 1)) ? S_PUSH : S_CH;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // Configuration, counters, left pixel, the top-left load flag and the output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_POINT;
         wlog_ff <= 4'd10;
         hlog_ff <= 4'd9;
         col_ff <= '0;
         row_ff <= '0;
         left_ff <= '0;
         tl_load_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODE: mode_ff <= csr_data[1:0];
               REG_WLOG: wlog_ff <= csr_data;
               REG_HLOG: hlog_ff <= csr_data;
               default: ;
            endcase
         end
         tl_load_ff <= accept && r[0] && !c[0];
         if (accept) begin
            if (last_col) begin
               col_ff <= '0;
               row_ff <= (r + 1'b1) & hmask;
            end else begin
               col_ff <= c + 1'b1;
               row_ff <= r;
            end
            if (r[0] && !c[0]) left_ff <= pix[MEM_W-1:0];
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Block datapath.
   always_ff @(posedge clock) begin
      if (tl_load_ff) tl_ff <= mem_q_ff;
      if (accept) begin
         br_ff <= pix[MEM_W-1:0];
         r_ff <= r;
         last_ff <= last_row && last_col;
      end
      if (state_ff == S_W0) begin
         tr_ff <= mem_q_ff;
         w0_ff <= rom_q;
         ch_ff <= 2'd0;
      end
      if (state_ff == S_W1) w1_ff <= rom_q;
      if (state_ff == S_CH) prod_ff <= NUM_W'(w0_ff) * NUM_W'(st);
      if (state_ff == S_MUL) num_ff <= prod_ff + NUM_W'(w1_ff) * NUM_W'(sb);
      if (res_load) begin
         res_ff[ch_ff] <= res_val;
         ch_ff <= ch_ff + 1'b1;
      end
      if (rsp_load) begin
         rsp_data_ff.red_out <= res_ff[0];
         rsp_data_ff.green_out <= res_ff[1];
         rsp_data_ff.blue_out <= res_ff[2];
         rsp_data_ff.alpha_out <= res_ff[3];
         rsp_data_ff.level_done <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `ASSERT_NEVER(a_mem_port, clock, reset, mem_we && mem_re, "line buffer read and write together")
   `ASSERT_PROP(a_rsp_free, clock, reset, rsp_load |-> (!rsp_valid_ff || rsp_ready), "result overwritten")
   `ASSERT_PROP(a_div_mode, clock, reset, div_start |-> (mode_ff == MODE_EQUI), "divide outside equirect")

endmodule
`default_nettype wire
